>>> hdl/i2cm_pkg.sv
// i2cm_pkg: shared types, codes and helpers for the i2c master byte engine
// used by the front, the command queue, the bit engine and the top level
// depends on nothing
package i2cm_pkg;

	localparam int DELAY_W     = 16;
	localparam int CFG_W       = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = CFG_W'(250);
	localparam logic [32:0]      DELAY_MAX         = (33'd1 << DELAY_W) - 33'd1;
	localparam logic [7:0]       MSB_MASK          = 8'h80;
	localparam logic [3:0]       BITS_PER_BYTE     = 4'd8;

	// raw kind codes on the input channel
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_START = 3'd1;
	localparam logic [2:0] KIND_STOP  = 3'd2;
	localparam logic [2:0] KIND_WRITE = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_data;
		logic       send_ack;
		logic       sda_in;
	} item_t;

	typedef enum logic [13:0] {
		PH_IDLE = 14'b00000000000001,
		PH_ST_A = 14'b00000000000010,
		PH_ST_B = 14'b00000000000100,
		PH_ST_C = 14'b00000000001000,
		PH_SP_A = 14'b00000000010000,
		PH_SP_B = 14'b00000000100000,
		PH_WR_A = 14'b00000001000000,
		PH_WR_B = 14'b00000010000000,
		PH_WK_A = 14'b00000100000000,
		PH_WK_B = 14'b00001000000000,
		PH_RD_A = 14'b00010000000000,
		PH_RD_B = 14'b00100000000000,
		PH_RK_A = 14'b01000000000000,
		PH_RK_B = 14'b10000000000000
	} phase_t;

	// length of one delay unit: zero acts as one, saturates at the counter range
	function automatic logic [DELAY_W-1:0] unit_len(input logic [CFG_W-1:0] cfg);
		logic [32:0] h;
		h = 33'(cfg);
		if (h == 33'd0) begin
			h = 33'd1;
		end
		if (h > DELAY_MAX) begin
			h = DELAY_MAX;
		end
		return h[DELAY_W-1:0];
	endfunction

endpackage

>>> hdl/i2cm_front.sv
// i2cm_front: input side of the engine, takes ticks and decodes the kind code
// depends on i2cm_pkg; feeds i2cm_queue
module i2cm_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        kind,
	input  logic [7:0]        tx_data,
	input  logic              send_ack,
	input  logic              sda_in,
	input  logic              q_full,
	output logic              q_push,
	output i2cm_pkg::item_t   q_item
);
	import i2cm_pkg::*;

	cmd_t cmd;

	// unknown kinds behave as a plain tick
	always_comb begin
		unique case (kind)
			KIND_START: cmd = CMD_START;
			KIND_STOP:  cmd = CMD_STOP;
			KIND_WRITE: cmd = CMD_WRITE;
			KIND_READ:  cmd = CMD_READ;
			default:    cmd = CMD_NONE;
		endcase
	end

	assign in_stall         = q_full;
	assign q_push           = in_valid && !q_full;
	assign q_item.cmd       = cmd;
	assign q_item.tx_data   = tx_data;
	assign q_item.send_ack  = send_ack;
	assign q_item.sda_in    = sda_in;

endmodule

>>> hdl/i2cm_queue.sv
// i2cm_queue: short fifo of decoded ticks between the front and the bit engine
// depends on i2cm_pkg
module i2cm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  i2cm_pkg::item_t   push_item,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output i2cm_pkg::item_t   head_item
);
	import i2cm_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/i2cm_back.sv
// i2cm_back: bit engine, runs start/stop/write/read sequences one tick at a time
// depends on i2cm_pkg; its state registers double as the output register
module i2cm_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [i2cm_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                         head_valid,
	input  i2cm_pkg::item_t              head_item,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         scl_level,
	output logic                         sda_level,
	output logic                         busy_res,
	output logic                         done_res,
	output logic [7:0]                   rx_byte,
	output logic                         nack_seen
);
	import i2cm_pkg::*;

	logic [CFG_W-1:0]   half_q;
	phase_t             phase_q, phase_n;
	logic [3:0]         bit_idx_q, bit_idx_n;
	logic [7:0]         shift_q, shift_n;
	logic [DELAY_W-1:0] delay_q, delay_n, dc_dec;
	logic               scl_q, scl_n;
	logic               sda_q, sda_n;
	logic               ack_choice_q, ack_choice_n;
	logic               ack_res_q, ack_res_n;
	logic [7:0]         rx_q, rx_n;
	logic               done_q, done_n;
	logic               out_valid_q;
	logic               step;
	logic [DELAY_W-1:0] unit;
	logic [3:0]         idx_inc;
	logic [7:0]         shl;

	assign step    = head_valid && (!out_valid_q || !out_stall);
	assign pop     = step;
	assign unit    = unit_len(half_q);
	assign idx_inc = bit_idx_q + 4'd1;
	assign shl     = {shift_q[6:0], 1'b0};
	assign dc_dec  = (delay_q != '0) ? delay_q - DELAY_W'(1) : '0;

	always_comb begin
		phase_n      = phase_q;
		bit_idx_n    = bit_idx_q;
		shift_n      = shift_q;
		delay_n      = delay_q;
		scl_n        = scl_q;
		sda_n        = sda_q;
		ack_choice_n = ack_choice_q;
		ack_res_n    = ack_res_q;
		rx_n         = rx_q;
		done_n       = 1'b0;
		if (phase_q != PH_IDLE) begin
			// commands arriving while busy are dropped
			delay_n = dc_dec;
			if (dc_dec == '0) begin
				unique case (phase_q)
					PH_ST_A: begin
						sda_n = 1'b0; phase_n = PH_ST_B; delay_n = unit;
					end
					PH_ST_B: begin
						scl_n = 1'b0; phase_n = PH_ST_C; delay_n = unit;
					end
					PH_SP_A: begin
						sda_n = 1'b1; phase_n = PH_SP_B; delay_n = unit;
					end
					PH_WR_A: begin
						scl_n = 1'b1; phase_n = PH_WR_B; delay_n = unit;
					end
					PH_WR_B: begin
						scl_n     = 1'b0;
						shift_n   = shl;
						bit_idx_n = idx_inc;
						delay_n   = unit;
						if (idx_inc >= BITS_PER_BYTE) begin
							sda_n   = 1'b1;
							phase_n = PH_WK_A;
						end else begin
							sda_n   = |(shl & MSB_MASK);
							phase_n = PH_WR_A;
						end
					end
					PH_WK_A: begin
						scl_n = 1'b1; phase_n = PH_WK_B; delay_n = unit;
					end
					PH_WK_B: begin
						ack_res_n = head_item.sda_in;
						scl_n     = 1'b0;
						phase_n   = PH_IDLE;
						done_n    = 1'b1;
					end
					PH_RD_A: begin
						shift_n = {shift_q[6:0], head_item.sda_in};
						scl_n   = 1'b0;
						phase_n = PH_RD_B;
						delay_n = unit;
					end
					PH_RD_B: begin
						bit_idx_n = idx_inc;
						delay_n   = unit;
						if (idx_inc >= BITS_PER_BYTE) begin
							rx_n    = shift_q;
							sda_n   = !ack_choice_q;
							phase_n = PH_RK_A;
						end else begin
							scl_n   = 1'b1;
							phase_n = PH_RD_A;
						end
					end
					PH_RK_A: begin
						scl_n = 1'b1; phase_n = PH_RK_B; delay_n = unit;
					end
					PH_RK_B: begin
						scl_n   = 1'b0;
						sda_n   = 1'b1;
						phase_n = PH_IDLE;
						done_n  = 1'b1;
					end
					default: begin
						// last segment of start or stop
						phase_n = PH_IDLE;
						done_n  = 1'b1;
					end
				endcase
			end
		end else begin
			bit_idx_n = '0;
			unique case (head_item.cmd)
				CMD_START: begin
					sda_n = 1'b1; scl_n = 1'b1; phase_n = PH_ST_A; delay_n = unit;
				end
				CMD_STOP: begin
					sda_n = 1'b0; scl_n = 1'b1; phase_n = PH_SP_A; delay_n = unit;
				end
				CMD_WRITE: begin
					shift_n = head_item.tx_data;
					sda_n   = |(head_item.tx_data & MSB_MASK);
					phase_n = PH_WR_A;
					delay_n = unit;
				end
				CMD_READ: begin
					shift_n      = '0;
					ack_choice_n = head_item.send_ack;
					sda_n        = 1'b1;
					scl_n        = 1'b1;
					phase_n      = PH_RD_A;
					delay_n      = unit;
				end
				default: begin
					bit_idx_n = bit_idx_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			shift_q <= shift_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q       <= HALF_PERIOD_RESET;
			phase_q      <= PH_IDLE;
			bit_idx_q    <= '0;
			delay_q      <= '0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			ack_choice_q <= 1'b0;
			ack_res_q    <= 1'b0;
			rx_q         <= '0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				half_q <= cfg_wr_data;
			end
			if (step) begin
				phase_q      <= phase_n;
				bit_idx_q    <= bit_idx_n;
				delay_q      <= delay_n;
				scl_q        <= scl_n;
				sda_q        <= sda_n;
				ack_choice_q <= ack_choice_n;
				ack_res_q    <= ack_res_n;
				rx_q         <= rx_n;
				done_q       <= done_n;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = scl_q;
	assign sda_level = sda_q;
	assign busy_res  = (phase_q != PH_IDLE);
	assign done_res  = done_q;
	assign rx_byte   = rx_q;
	assign nack_seen = ack_res_q;

endmodule

>>> hdl/i2c_master_byte_engine.sv
// i2c_master_byte_engine: one result per input tick, presented from the output register after the
// input transaction has passed through the queue; sustains one tick per cycle while the output is not
// stalled; the two-entry queue lets input run while output stalls
// asynchronous active-low reset: engine idle, scl and sda released, queue empty,
// received byte and ack flag cleared, delay unit 250 ticks
// depends on i2cm_pkg, i2cm_front, i2cm_queue, i2cm_back
module i2c_master_byte_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [i2cm_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   kind,
	input  logic [7:0]                   tx_data,
	input  logic                         send_ack,
	input  logic                         sda_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         scl_level,
	output logic                         sda_level,
	output logic                         busy_res,
	output logic                         done_res,
	output logic [7:0]                   rx_byte,
	output logic                         nack_seen
);
	import i2cm_pkg::*;

	logic  q_full;
	logic  q_push;
	item_t q_item;
	logic  head_valid;
	item_t head_item;
	logic  pop;

	i2cm_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.tx_data  (tx_data),
		.send_ack (send_ack),
		.sda_in   (sda_in),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	i2cm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	i2cm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.scl_level   (scl_level),
		.sda_level   (sda_level),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.rx_byte     (rx_byte),
		.nack_seen   (nack_seen)
	);

endmodule

>>> hdl/i2cm_checker.sv
// i2cm_checker: port-level checks on the i2c master byte engine
// depends only on the top-level ports; bound to i2c_master_byte_engine
module i2cm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         scl_level,
	input logic                         sda_level,
	input logic                         busy_res,
	input logic                         done_res,
	input logic [7:0]                   rx_byte,
	input logic                         nack_seen
);

	// a stalled result transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scl_level) && $stable(sda_level)
		&& $stable(busy_res) && $stable(done_res) && $stable(rx_byte) && $stable(nack_seen))
		else $error("result changed while stalled");

	// a finishing command leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && busy_res))
		else $error("done reported while still busy");

	a_rst_out: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_rst_in: assert property (@(posedge clk) !arst_n |-> !in_stall)
		else $error("input stalled during reset");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);

>>> tb/sv/i2c_master_byte_engine_test.sv
// i2c_master_byte_engine_test: self-checking testbench for the i2c master byte engine
// a tick-level line predictor inside a scoreboard class checks every result transaction
// depends on i2cm_pkg and i2c_master_byte_engine
`timescale 1ns / 1ps

module i2c_master_byte_engine_test;
	import i2cm_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int REPORT_MAX  = 10;
	localparam int SETTLE_TAIL = 20;

	// how the sda_in level is chosen while a command runs
	localparam int SDA_LOW      = 0;
	localparam int SDA_RELEASED = 1;
	localparam int SDA_RANDOM   = 2;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       nack;
	} line_state_t;

	class line_scoreboard;
		logic [CFG_W-1:0]   unit_cfg;
		phase_t             ph;
		logic [2:0]         op;
		logic [3:0]         bit_cnt;
		logic [7:0]         shifter;
		logic [DELAY_W-1:0] wait_cnt;
		logic               scl_q;
		logic               sda_q;
		logic               ack_pick;
		logic               ack_got;
		logic [7:0]         rx_last;
		line_state_t        expected_lines[$];
		int                 mismatches;
		int                 orphans;
		int                 reported;
		int                 checked;
		int                 cmds_started;

		function new();
			unit_cfg = HALF_PERIOD_RESET;
			ph = PH_IDLE;
			op = KIND_TICK;
			bit_cnt = '0;
			shifter = '0;
			wait_cnt = '0;
			scl_q = 1'b1;
			sda_q = 1'b1;
			ack_pick = 1'b0;
			ack_got = 1'b0;
			rx_last = '0;
			mismatches = 0;
			orphans = 0;
			reported = 0;
			checked = 0;
			cmds_started = 0;
		endfunction

		function bit busy();
			return ph != PH_IDLE;
		endfunction

		// zero acts as one tick, anything beyond the counter saturates
		function logic [DELAY_W-1:0] unit_ticks();
			logic [32:0] u;
			logic [32:0] top;
			top = (33'd1 << DELAY_W) - 33'd1;
			u = 33'(unit_cfg);
			if (u == 33'd0) begin
				u = 33'd1;
			end
			if (u > top) begin
				u = top;
			end
			return u[DELAY_W-1:0];
		endfunction

		function void enter(phase_t nxt);
			ph = nxt;
			wait_cnt = unit_ticks();
		endfunction

		// closes the current segment, returns 1 when the command is complete
		function bit close_segment(logic sdi);
			case (ph)
				PH_ST_A: begin
					sda_q = 1'b0;
					enter(PH_ST_B);
				end
				PH_ST_B: begin
					scl_q = 1'b0;
					enter(PH_ST_C);
				end
				PH_SP_A: begin
					sda_q = 1'b1;
					enter(PH_SP_B);
				end
				PH_WR_A: begin
					scl_q = 1'b1;
					enter(PH_WR_B);
				end
				PH_WR_B: begin
					scl_q = 1'b0;
					shifter = shifter << 1;
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt >= BITS_PER_BYTE) begin
						sda_q = 1'b1;
						enter(PH_WK_A);
					end else begin
						sda_q = shifter[7];
						enter(PH_WR_A);
					end
				end
				PH_WK_A: begin
					scl_q = 1'b1;
					enter(PH_WK_B);
				end
				PH_WK_B: begin
					ack_got = sdi;
					scl_q = 1'b0;
					return 1'b1;
				end
				PH_RD_A: begin
					shifter = {shifter[6:0], sdi};
					scl_q = 1'b0;
					enter(PH_RD_B);
				end
				PH_RD_B: begin
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt >= BITS_PER_BYTE) begin
						rx_last = shifter;
						sda_q = !ack_pick;
						enter(PH_RK_A);
					end else begin
						scl_q = 1'b1;
						enter(PH_RD_A);
					end
				end
				PH_RK_A: begin
					scl_q = 1'b1;
					enter(PH_RK_B);
				end
				PH_RK_B: begin
					scl_q = 1'b0;
					sda_q = 1'b1;
					return 1'b1;
				end
				default: begin
					return 1'b1;
				end
			endcase
			return 1'b0;
		endfunction

		function void note_input(logic [2:0] k, logic [7:0] tx, logic sack, logic sdi);
			logic        finished;
			line_state_t e;
			finished = 1'b0;
			if (ph != PH_IDLE) begin
				if (wait_cnt != 0) begin
					wait_cnt = wait_cnt - 1'b1;
				end
				if (wait_cnt == 0 && close_segment(sdi)) begin
					ph = PH_IDLE;
					finished = 1'b1;
				end
			end else if (k >= KIND_START && k <= KIND_READ) begin
				cmds_started++;
				op = k;
				bit_cnt = '0;
				case (k)
					KIND_START: begin
						sda_q = 1'b1;
						scl_q = 1'b1;
						enter(PH_ST_A);
					end
					KIND_STOP: begin
						sda_q = 1'b0;
						scl_q = 1'b1;
						enter(PH_SP_A);
					end
					KIND_WRITE: begin
						shifter = tx;
						sda_q = tx[7];
						enter(PH_WR_A);
					end
					default: begin
						shifter = '0;
						ack_pick = sack;
						sda_q = 1'b1;
						scl_q = 1'b1;
						enter(PH_RD_A);
					end
				endcase
			end
			e = '{scl_q, sda_q, ph != PH_IDLE, finished, rx_last, ack_got};
			expected_lines.push_back(e);
		endfunction

		function void check_result(line_state_t got);
			line_state_t e;
			if (expected_lines.size() == 0) begin
				orphans++;
				if (reported < REPORT_MAX) begin
					reported++;
					$display("unexpected result transaction: scl %b sda %b busy %b done %b rx %h nack %b",
						got.scl, got.sda, got.busy, got.done, got.rx, got.nack);
				end
				return;
			end
			e = expected_lines.pop_front();
			checked++;
			if (got.scl !== e.scl || got.sda !== e.sda || got.busy !== e.busy ||
					got.done !== e.done || got.rx !== e.rx || got.nack !== e.nack) begin
				mismatches++;
				if (reported < REPORT_MAX) begin
					reported++;
					$display("result %0d: exp scl %b sda %b busy %b done %b rx %h nack %b",
						checked, e.scl, e.sda, e.busy, e.done, e.rx, e.nack);
					$display("result %0d: got scl %b sda %b busy %b done %b rx %h nack %b",
						checked, got.scl, got.sda, got.busy, got.done, got.rx, got.nack);
				end
			end
		endfunction

		function int failures();
			return mismatches + orphans + expected_lines.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [2:0]       kind = KIND_TICK;
	logic [7:0]       tx_data = '0;
	logic             send_ack = 1'b0;
	logic             sda_in = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             scl_level;
	logic             sda_level;
	logic             busy_res;
	logic             done_res;
	logic [7:0]       rx_byte;
	logic             nack_seen;

	line_scoreboard sb = new();
	bit             send_gaps = 1'b0;
	bit             recv_gaps = 1'b0;
	bit             hold_req = 1'b0;
	int             items_sent = 0;
	int             live_items = 0;
	int             settings_used = 0;
	int             quiet_cycles = 0;

	i2c_master_byte_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.tx_data    (tx_data),
		.send_ack   (send_ack),
		.sda_in     (sda_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl_level  (scl_level),
		.sda_level  (sda_level),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.rx_byte    (rx_byte),
		.nack_seen  (nack_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// handshakes are sampled at the falling edge, where everything is settled
	always @(negedge clk) begin
		if (!arst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no transaction for %0d cycles, %0d results outstanding",
				quiet_cycles, sb.expected_lines.size());
			$display("i2c_master_byte_engine_test: errors");
			$finish;
		end
	end

	initial begin : result_sink
		int          gap;
		bit          got;
		line_state_t seen;
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = recv_gaps ? $urandom_range(19, 0) : 0;
				if (gap != 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				got = out_valid;
				seen = '{scl_level, sda_level, busy_res, done_res, rx_byte, nack_seen};
				@(posedge clk);
			end while (!got);
			sb.check_result(seen);
		end
	end

	function automatic logic pick_sda(int mode);
		if (mode == SDA_LOW) begin
			return 1'b0;
		end
		if (mode == SDA_RELEASED) begin
			return 1'b1;
		end
		return 1'($urandom);
	endfunction

	task automatic push_item(input logic [2:0] k, input logic [7:0] d, input logic a,
			input logic s);
		int gap;
		bit stalled;
		gap = send_gaps ? $urandom_range(19, 0) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		tx_data <= d;
		send_ack <= a;
		sda_in <= s;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		// a command landing on a busy engine is dropped and does not count
		if (!(sb.busy() && k >= KIND_START && k <= KIND_READ)) begin
			live_items++;
		end
		sb.note_input(k, d, a, s);
		items_sent++;
	endtask

	// issue one command and keep ticking until the engine is predicted idle again
	task automatic run_cmd(input logic [2:0] k, input logic [7:0] d, input logic a,
			input int sda_mode, input int noise_pct);
		logic [2:0] tk;
		push_item(k, d, a, pick_sda(sda_mode));
		while (sb.busy()) begin
			if ($urandom_range(99, 0) < noise_pct) begin
				tk = 3'($urandom_range(KIND_READ, KIND_START));
			end else if ($urandom_range(3, 0) == 0) begin
				tk = 3'($urandom_range(7, KIND_READ + 1));
			end else begin
				tk = KIND_TICK;
			end
			push_item(tk, 8'($urandom), 1'($urandom), pick_sda(sda_mode));
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_lines.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_unit(input logic [CFG_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.unit_cfg = v;
		settings_used++;
	endtask

	task automatic random_byte_cmd();
		if ($urandom_range(1, 0) == 1) begin
			run_cmd(KIND_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 15);
		end else begin
			run_cmd(KIND_READ, 8'($urandom), 1'($urandom), SDA_RANDOM, 15);
		end
	endtask

	task automatic random_phase(input int target, input int idx);
		int  first;
		int  n;
		bit  paused;
		first = live_items;
		paused = 1'b0;
		if (idx == 0) begin
			// long output hold-off while input keeps coming, so the queue fills
			hold_req = 1'b1;
			send_gaps = 1'b0;
			run_cmd(KIND_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 15);
			run_cmd(KIND_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 15);
			send_gaps = 1'b1;
		end
		while (live_items - first < target) begin
			if (idx == 1 && !paused && live_items - first > target / 2) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(9, 0) == 0) begin
				// stray item: bare command, tick or reserved kind
				push_item(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				run_cmd(KIND_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 15);
				n = $urandom_range(4, 0);
				repeat (n) random_byte_cmd();
				if ($urandom_range(7, 0) != 0) begin
					run_cmd(KIND_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 15);
				end
			end
		end
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] units[5];
		arst_n <= 1'b0;
		units = '{16'd1, 16'd3, 16'd0, 16'd2, 16'd5};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset delay unit, commands thrown at the busy engine throughout
		push_item(KIND_TICK, 8'h00, 1'b0, 1'b0);
		run_cmd(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 100);
		drain_results();

		// zero unit behaves as one tick
		set_unit(16'd0);
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		for (int k = KIND_READ + 1; k < 8; k++) begin
			push_item(3'(k), 8'($urandom), 1'($urandom), 1'($urandom));
		end
		run_cmd(KIND_START, 8'h00, 1'b0, SDA_RANDOM, 0);
		run_cmd(KIND_WRITE, 8'hFF, 1'b0, SDA_LOW, 100);
		run_cmd(KIND_WRITE, 8'h00, 1'b1, SDA_RELEASED, 0);
		run_cmd(KIND_READ, 8'h5A, 1'b1, SDA_RELEASED, 0);
		run_cmd(KIND_READ, 8'hA5, 1'b0, SDA_LOW, 100);
		run_cmd(KIND_READ, 8'h00, 1'b1, SDA_RANDOM, 0);
		run_cmd(KIND_STOP, 8'hFF, 1'b1, SDA_RANDOM, 0);
		run_cmd(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
		run_cmd(KIND_WRITE, 8'h80, 1'b0, SDA_RANDOM, 0);
		drain_results();

		for (int p = 0; p < 5; p++) begin
			set_unit(units[p]);
			send_gaps = (p != 2);
			recv_gaps = (p != 3);
			random_phase(60, p);
			drain_results();
		end

		repeat (SETTLE_TAIL) @(posedge clk);
		$display("sent %0d input transactions (%0d commands started), checked %0d results",
			items_sent, sb.cmds_started, sb.checked);
		$display("%0d delay settings; %0d mismatches, %0d unexpected, %0d missing",
			settings_used, sb.mismatches, sb.orphans, sb.expected_lines.size());
		if (sb.failures() == 0) begin
			$display("i2c_master_byte_engine_test: clean");
		end else begin
			$display("i2c_master_byte_engine_test: errors");
		end
		$finish;
	end

endmodule
